>>> sv/lpfd_pkg.sv
`default_nettype none
package lpfd_pkg;

   localparam int unsigned HDR_BYTES = 5;
   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'(128 * 1024);
   localparam logic [2:0] HDR_LAST_IDX = 3'(HDR_BYTES - 1);

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_HEADER  = 2'd1,
      KIND_DROP    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_SKIP    = 3'b100
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  out_byte;
      logic [31:0] frame_length;
      logic        is_last;
   } result_type;

endpackage
`default_nettype wire

>>> sv/lpfd_req_if.sv
`default_nettype none
interface lpfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

>>> sv/lpfd_rsp_if.sv
`default_nettype none
interface lpfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  out_byte;
   logic [31:0] frame_length;
   logic        is_last;

   modport source (output valid, output kind, output out_byte, output frame_length,
                   output is_last, input ready);
   modport sink (input valid, input kind, input out_byte, input frame_length,
                 input is_last, output ready);
endinterface
`default_nettype wire

>>> sv/lpfd_core.sv
`default_nettype none
module lpfd_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [7:0]         in_byte,
   input  wire logic [31:0]        max_payload,
   output logic                    res_valid,
   input  wire logic               res_ready,
   output lpfd_pkg::result_type    res
);

   logic                 beat_valid_ff;
   logic                 beat_valid_in;
   logic [7:0]           beat_byte_ff;
   lpfd_pkg::phase_type  phase_ff, phase_in;
   logic [2:0]           count_ff, count_in;
   logic [7:0]           type_ff, type_in;
   logic [31:0]          length_ff, length_in;
   logic [31:0]          remaining_ff, remaining_in;
   logic [31:0]          length_next;
   logic                 last_byte;
   logic                 emit;
   logic                 fire;

   assign length_next = {length_ff[23:0], beat_byte_ff};
   assign last_byte   = (remaining_ff == 32'd1);

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      type_in      = type_ff;
      length_in    = length_ff;
      remaining_in = remaining_ff;
      emit         = 1'b0;
      res          = '{kind: lpfd_pkg::KIND_PAYLOAD, out_byte: beat_byte_ff,
                       frame_length: 32'd0, is_last: 1'b0};
      unique case (phase_ff)
         lpfd_pkg::PH_PAYLOAD: begin
            remaining_in = remaining_ff - 32'd1;
            emit         = 1'b1;
            res.is_last  = last_byte;
            if (last_byte) begin
               phase_in = lpfd_pkg::PH_HEADER;
               count_in = 3'd0;
            end
         end
         lpfd_pkg::PH_SKIP: begin
            remaining_in = remaining_ff - 32'd1;
            if (last_byte) begin
               phase_in = lpfd_pkg::PH_HEADER;
               count_in = 3'd0;
               emit     = 1'b1;
               res      = '{kind: lpfd_pkg::KIND_DROP, out_byte: type_ff,
                            frame_length: length_ff, is_last: 1'b1};
            end
         end
         default: begin
            phase_in = lpfd_pkg::PH_HEADER;
            if (phase_ff != lpfd_pkg::PH_HEADER || count_ff == 3'd0) begin
               type_in   = beat_byte_ff;
               length_in = 32'd0;
               count_in  = 3'd1;
            end else begin
               length_in = length_next;
               if (count_ff < lpfd_pkg::HDR_LAST_IDX) begin
                  count_in = count_ff + 3'd1;
               end else begin
                  count_in = 3'd0;
                  res      = '{kind: lpfd_pkg::KIND_HEADER, out_byte: type_ff,
                               frame_length: 32'd0, is_last: 1'b1};
                  if (length_next == 32'd0) begin
                     emit = 1'b1;
                  end else begin
                     remaining_in = length_next;
                     if (length_next > max_payload) begin
                        phase_in = lpfd_pkg::PH_SKIP;
                     end else begin
                        phase_in         = lpfd_pkg::PH_PAYLOAD;
                        emit             = 1'b1;
                        res.frame_length = length_next;
                        res.is_last      = 1'b0;
                     end
                  end
               end
            end
         end
      endcase
   end

   assign res_valid     = beat_valid_ff && emit;
   assign fire          = beat_valid_ff && (!emit || res_ready);
   assign in_ready      = !beat_valid_ff || fire;
   assign beat_valid_in = in_valid ? 1'b1 : (beat_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_valid_ff <= 1'b0;
         phase_ff      <= lpfd_pkg::PH_HEADER;
         count_ff      <= 3'd0;
         type_ff       <= 8'd0;
         length_ff     <= 32'd0;
         remaining_ff  <= 32'd0;
      end else begin
         if (in_ready) begin
            beat_valid_ff <= beat_valid_in;
         end
         if (fire) begin
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            type_ff      <= type_in;
            length_ff    <= length_in;
            remaining_ff <= remaining_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         beat_byte_ff <= in_byte;
      end
   end

   a_remaining_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lpfd_pkg::PH_PAYLOAD || phase_ff == lpfd_pkg::PH_SKIP)
      |-> remaining_ff != 32'd0)
      else $error("payload or skip phase with nothing remaining");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lpfd_pkg::HDR_LAST_IDX)
      else $error("header count out of range");

   a_skip_silent: assert property (@(posedge clock) disable iff (reset)
      beat_valid_ff && phase_ff == lpfd_pkg::PH_SKIP && !last_byte |-> !res_valid)
      else $error("result emitted for a skipped byte");

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("phase register corrupted");

endmodule
`default_nettype wire

>>> sv/lpfd_out_reg.sv
`default_nettype none
module lpfd_out_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire lpfd_pkg::result_type in_data,
   lpfd_rsp_if.source              rsp_bus
);

   logic                  valid_ff;
   logic                  valid_in;
   lpfd_pkg::result_type  data_ff;

   assign in_ready = !valid_ff || rsp_bus.ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.kind         = data_ff.kind;
   assign rsp_bus.out_byte     = data_ff.out_byte;
   assign rsp_bus.frame_length = data_ff.frame_length;
   assign rsp_bus.is_last      = data_ff.is_last;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff)
      else $error("loaded result not presented");

endmodule
`default_nettype wire

>>> sv/length_prefixed_frame_deframer_top.sv
// Length-prefixed frame deframer.
// req_bus: raw stream, one byte per beat (valid/ready).
// rsp_bus: one result per beat: kind 0 payload byte, kind 1 header accepted
//   (type in out_byte, length in frame_length), kind 2 oversized frame dropped.
//   is_last marks the beat that ends a frame.
// Each frame is a type byte plus a 32-bit big-endian length, then the payload.
// Frames longer than max_payload produce no header or payload beats; a single
// drop beat follows the last skipped payload byte.
// csr_wr_en/csr_wr_data write max_payload (reset 128 KiB); write only while idle.
// An accepted byte is held in the input register, its result in the result
//   register. Throughput: one byte per cycle while rsp_bus keeps up; set by the
//   input-to-result register step, a 32-bit compare and a 32-bit decrement.
// Reset: synchronous, clears the parser to expect a header and empties both
//   registers. When rsp_bus stalls, the result register holds, the input
//   register fills, and req_bus.ready drops; header and skipped bytes that make
//   no result keep flowing even while the result register waits.
`default_nettype none
module length_prefixed_frame_deframer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   lpfd_req_if.sink         req_bus,
   lpfd_rsp_if.source       rsp_bus,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   logic [31:0]           max_payload_ff;
   logic                  res_valid;
   logic                  res_ready;
   lpfd_pkg::result_type  res;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= lpfd_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_wr_en) begin
         max_payload_ff <= csr_wr_data;
      end
   end

   lpfd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_bus.valid),
      .in_ready    (req_bus.ready),
      .in_byte     (req_bus.in_byte),
      .max_payload (max_payload_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   lpfd_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_ready (res_ready),
      .in_data  (res),
      .rsp_bus  (rsp_bus)
   );

endmodule
`default_nettype wire

>>> tb/lpfd_frame_checker.sv
module lpfd_frame_checker (
   input  logic        clock,
   input  logic        reset,
   lpfd_req_if         req_mon,
   lpfd_rsp_if         rsp_mon,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output int          pending_results,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   lpfd_pkg::phase_type   parse_phase;
   logic [2:0]            hdr_seen;
   logic [7:0]            cur_type;
   logic [31:0]           cur_length;
   logic [31:0]           left_count;
   logic [31:0]           size_limit;
   lpfd_pkg::result_type  expected_results[$];
   int                    errors = 0;

   // Advances the frame parser by one byte; returns 1 when the byte yields a result beat.
   function automatic bit parse_byte(input logic [7:0] b, output lpfd_pkg::result_type r);
      r = '{lpfd_pkg::KIND_PAYLOAD, b, 32'd0, 1'b0};
      case (parse_phase)
         lpfd_pkg::PH_PAYLOAD: begin
            left_count = left_count - 1;
            if (left_count == 0) begin
               parse_phase = lpfd_pkg::PH_HEADER;
               hdr_seen = 3'd0;
               r.is_last = 1'b1;
            end
            return 1'b1;
         end
         lpfd_pkg::PH_SKIP: begin
            left_count = left_count - 1;
            if (left_count != 0)
               return 1'b0;
            parse_phase = lpfd_pkg::PH_HEADER;
            hdr_seen = 3'd0;
            r = '{lpfd_pkg::KIND_DROP, cur_type, cur_length, 1'b1};
            return 1'b1;
         end
         default: begin
            if (parse_phase != lpfd_pkg::PH_HEADER) begin
               parse_phase = lpfd_pkg::PH_HEADER;
               hdr_seen = 3'd0;
            end
            if (hdr_seen == 3'd0) begin
               cur_type = b;
               cur_length = 32'd0;
               hdr_seen = 3'd1;
               return 1'b0;
            end
            cur_length = {cur_length[23:0], b};
            if (hdr_seen < lpfd_pkg::HDR_LAST_IDX) begin
               hdr_seen = hdr_seen + 3'd1;
               return 1'b0;
            end
            hdr_seen = 3'd0;
            if (cur_length == 0) begin
               r = '{lpfd_pkg::KIND_HEADER, cur_type, 32'd0, 1'b1};
               return 1'b1;
            end
            left_count = cur_length;
            if (cur_length > size_limit) begin
               parse_phase = lpfd_pkg::PH_SKIP;
               return 1'b0;
            end
            parse_phase = lpfd_pkg::PH_PAYLOAD;
            r = '{lpfd_pkg::KIND_HEADER, cur_type, cur_length, 1'b0};
            return 1'b1;
         end
      endcase
   endfunction

   function automatic int field_diff(input string name, input logic [31:0] want,
                                     input logic [31:0] seen);
      if (want !== seen) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      lpfd_pkg::result_type want;
      bit                   produced;
      if (reset) begin
         parse_phase = lpfd_pkg::PH_HEADER;
         hdr_seen = 3'd0;
         cur_type = 8'd0;
         cur_length = 32'd0;
         left_count = 32'd0;
         size_limit = lpfd_pkg::MAX_PAYLOAD_RESET;
         expected_results.delete();
      end else begin
         if (csr_wr_en)
            size_limit = csr_wr_data;
         if (req_mon.valid && req_mon.ready) begin
            produced = parse_byte(req_mon.in_byte, want);
            if (produced)
               expected_results.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("result beat with none expected: kind %0d byte 0x%0h",
                      rsp_mon.kind, rsp_mon.out_byte);
               errors++;
            end else begin
               want = expected_results.pop_front();
               errors += field_diff("kind", 32'(want.kind), 32'(rsp_mon.kind));
               errors += field_diff("out_byte", 32'(want.out_byte),
                                    32'(rsp_mon.out_byte));
               errors += field_diff("frame_length", want.frame_length, rsp_mon.frame_length);
               errors += field_diff("is_last", 32'(want.is_last), 32'(rsp_mon.is_last));
            end
         end
      end
      pending_results <= expected_results.size();
      fail_count <= errors;
   end

endmodule

>>> tb/length_prefixed_frame_deframer_top_test.sv
module length_prefixed_frame_deframer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_BYTES = 300;
   localparam int NUM_PHASES = 6;
   localparam int HOLD_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   int          pending_results;
   int          fail_count;

   bit          gaps_on;
   int          burst_left;
   int          bytes_sent;
   bit          want_hold;

   lpfd_req_if req_bus ();
   lpfd_rsp_if rsp_bus ();

   length_prefixed_frame_deframer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lpfd_frame_checker frame_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .pending_results (pending_results),
      .fail_count      (fail_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic send_byte(input logic [7:0] b);
      int gap_len;
      if (gaps_on && burst_left == 0) begin
         gap_len = $urandom_range(1, 6);
         repeat (gap_len) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
            req_bus.in_byte = 8'($urandom);
         end
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0)
         burst_left--;
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.in_byte = b;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [7:0] ftype, input logic [31:0] len);
      send_byte(ftype);
      send_byte(len[31:24]);
      send_byte(len[23:16]);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
   endtask

   task automatic send_frame(input logic [7:0] ftype, input logic [31:0] len);
      send_header(ftype, len);
      repeat (len) send_byte(8'($urandom));
   endtask

   // Drain before touching max_payload: results first, then bytes that make none.
   task automatic set_max_payload(input logic [31:0] v);
      @(negedge clock);
      req_bus.valid = 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [31:0] pick_length(input logic [31:0] limit);
      int r;
      r = $urandom_range(0, 99);
      if (r < 10 && limit < 600)
         return limit + 32'($urandom_range(0, 1));
      if (r < 65)
         return $urandom_range(0, 24);
      if (r < 80)
         return $urandom_range(0, 3);
      if (r < 95)
         return $urandom_range(25, 200);
      return $urandom_range(200, 600);
   endfunction

   // Receiver: rotating ready pattern, plus one long hold-off on request.
   initial begin
      logic [15:0] pattern;
      logic [3:0]  idx;
      int          pattern_age;
      int          hold_left;
      bit          hold_done;
      rsp_bus.ready = 1'b0;
      idx = 4'd0;
      pattern_age = 0;
      hold_left = 0;
      hold_done = 1'b0;
      pattern = '1;
      forever begin
         @(negedge clock);
         if (want_hold && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            if (pattern_age == 0) begin
               case ($urandom_range(0, 3))
                  0: pattern = '1;
                  1: pattern = 16'($urandom);
                  2: pattern = 16'($urandom) & 16'($urandom);
                  default: pattern = 16'($urandom) | 16'($urandom);
               endcase
               pattern[0] = 1'b1;
               pattern_age = $urandom_range(16, 96);
            end
            pattern_age--;
            rsp_bus.ready = pattern[idx];
            idx = idx + 4'd1;
         end
      end
   end

   initial begin
      logic [31:0] limit;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.in_byte = 8'd0;
      csr_wr_en = 1'b0;
      csr_wr_data = 32'd0;
      want_hold = 1'b0;
      gaps_on = 1'b1;
      burst_left = 0;
      bytes_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero length, length at and above the limit, zero length under a zero limit
      send_header(8'h00, 32'd0);
      set_max_payload(32'd2);
      send_header(8'hFF, 32'd2);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(8'h81, 32'd3);
      set_max_payload(32'd0);
      send_header(8'h7E, 32'd0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: limit = lpfd_pkg::MAX_PAYLOAD_RESET;
            1: limit = 32'hFFFF_FFFF;
            2: limit = 32'd0;
            3: limit = 32'd1;
            4: limit = 32'd16;
            default: limit = $urandom_range(0, 300);
         endcase
         set_max_payload(limit);
         gaps_on = (p == 0) ? 1'b0 : 1'($urandom);
         burst_left = 0;
         @(posedge clock);
         if (p == 1)
            want_hold = 1'b1;
         bytes_sent = 0;
         while (bytes_sent < PHASE_BYTES)
            send_frame(8'($urandom), pick_length(limit));
      end

      @(negedge clock);
      req_bus.valid = 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("length_prefixed_frame_deframer_top verification clean");
      else
         $display("length_prefixed_frame_deframer_top verification failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("length_prefixed_frame_deframer_top verification failed");
      $finish;
   end

endmodule
